// ----- design/irn_pkg.sv -----
// Package of the image range normalizer: mapping mode codes, constants and
// the queue entry that passes from the front end to the back end.
// No dependencies.
`default_nettype none
package irn_pkg;

  localparam logic [1:0] MODE_CENTER  = 2'd0;
  localparam logic [1:0] MODE_STRETCH = 2'd1;
  localparam logic [1:0] MODE_OFFSET  = 2'd2;
  localparam logic [1:0] MODE_ROUND   = 2'd3;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  localparam int NUM_W = 40;
  localparam int DEN_W = 32;

  localparam logic [23:0] PIX_RED   = 24'h0000FF;
  localparam logic [23:0] PIX_WHITE = 24'hFFFFFF;

  // One pixel job: either a finished pixel or a division num / den that
  // gives the gray level, saturated at 255.
  typedef struct packed {
    logic             do_div;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [23:0]      pix;   // red in bits 7:0, green 15:8, blue 23:16
  } job_t;

  function automatic logic [23:0] gray(input logic [7:0] g);
    return {g, g, g};
  endfunction

endpackage
`default_nettype wire

// ----- design/irn_fifo.sv -----
// Two-entry queue of pixel jobs between the front end and the back end.
// Depends on irn_pkg for job_t.
`default_nettype none
module irn_fifo import irn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  job_t      wr_data,
  output logic      full,
  input  wire logic rd,
  output logic      not_empty,
  output job_t      rd_data
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign rd_data   = mem[rptr];

endmodule
`default_nettype wire

// ----- design/irn_front.sv -----
// Front end: takes input transactions, keeps the frame extremes and the mode
// register, and turns each map sample into a pixel job. Depends on irn_pkg.
`default_nettype none
module irn_front import irn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        take,
  input  wire logic        cmd,
  input  wire logic [31:0] sample,
  input  wire logic        sample_is_nan,
  input  wire logic        frame_first,
  output logic             q_wr,
  output job_t             q_data
);

  logic [1:0]         map_mode;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic signed [31:0] lo_base;
  logic signed [31:0] hi_base;
  logic signed [31:0] s;
  logic [32:0]        d_w;
  logic [31:0]        d;
  logic signed [33:0] ds;
  logic signed [33:0] e;
  logic [39:0]        num0;
  logic [39:0]        num1;
  logic [32:0]        rnd;

  assign s = $signed(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode <= MODE_CENTER;
      lo       <= '0;
      hi       <= '0;
    end else begin
      if (cfg_we) map_mode <= cfg_wdata;
      if (take && cmd == CMD_SCAN) begin
        lo <= (!sample_is_nan && s < lo_base) ? s : lo_base;
        hi <= (!sample_is_nan && s > hi_base) ? s : hi_base;
      end
    end
  end

  always_comb begin
    lo_base = frame_first ? 32'sd0 : lo;
    hi_base = frame_first ? 32'sd0 : hi;
    d_w  = {hi[31], hi} - {lo[31], lo};
    d    = d_w[31:0];
    ds   = $signed({2'b00, d}) + $signed({{2{s[31]}}, s});
    e    = $signed({{2{s[31]}}, s}) - $signed({{2{lo[31]}}, lo});
    num0 = ({7'd0, ds[32:0]} << 7) - {7'd0, ds[32:0]};
    num1 = ({8'd0, e[31:0]} << 8) - {8'd0, e[31:0]};
    rnd  = {1'b0, sample} + 33'd32768;
  end

  always_comb begin
    q_wr          = take && cmd == CMD_MAP;
    q_data.do_div = 1'b0;
    q_data.num    = num0;
    q_data.den    = d;
    q_data.pix    = gray(8'd0);
    if (sample_is_nan) begin
      q_data.pix = PIX_RED;
    end else begin
      case (map_mode)
        MODE_CENTER: begin
          if (d == 32'd0) q_data.pix = gray(8'd127);
          else if (!ds[33]) q_data.do_div = 1'b1;
        end
        MODE_STRETCH: begin
          q_data.num = num1;
          if (d != 32'd0 && !e[33]) q_data.do_div = 1'b1;
        end
        MODE_OFFSET: begin
          if (e[33]) q_data.pix = PIX_RED;
          else if (e > 34'sd16711680) q_data.pix = PIX_WHITE;
          else q_data.pix = gray(e[23:16]);
        end
        default: begin
          if (s[31]) q_data.pix = gray(8'd0);
          else if (s > 32'sd16711680) q_data.pix = gray(8'd255);
          else q_data.pix = gray(rnd[23:16]);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/irn_back.sv -----
// Back end: runs the saturating gray division one quotient bit per cycle,
// holds the result while the output is stalled, and holds the output pixel register. Depends on irn_pkg.
`default_nettype none
module irn_back import irn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_not_empty,
  input  job_t       q_data,
  output logic       q_rd,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output logic [23:0] m_tdata
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t     state;
  logic [39:0] rem;
  logic [31:0] den;
  logic [3:0]  k;
  logic [6:0]  q;
  logic [39:0] den_sh;
  logic        ge;
  logic        out_free;
  logic        finish;
  logic [7:0]  result;
  logic        out_load;

  always_comb begin
    out_free = !m_tvalid || m_tready;
    den_sh   = {8'd0, den} << k;
    ge       = rem >= den_sh;
    finish   = state == ST_DIV && ((k == 4'd8 && ge) || k == 4'd0);
    result   = (k == 4'd8) ? 8'd255 : {q, ge};
    q_rd     = state == ST_IDLE && q_not_empty && (q_data.do_div || out_free);
    out_load = (q_rd && !q_data.do_div) || (finish && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_rd) begin
            if (q_data.do_div) begin
              state <= ST_DIV;
              rem   <= q_data.num;
              den   <= q_data.den;
              k     <= 4'd8;
              q     <= '0;
            end else begin
              m_tdata  <= q_data.pix;
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (finish) begin
            if (out_free) begin
              m_tdata  <= gray(result);
              m_tvalid <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            if (ge) rem <= rem - den_sh;
            if (k != 4'd8) q <= {q[5:0], ge};
            k <= k - 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> q_not_empty) else $error("queue read while empty");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("output overwritten");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && k != 4'd8) |-> rem < ({8'd0, den} << (k + 4'd1)))
    else $error("division remainder out of range");

endmodule
`default_nettype wire

// ----- design/image_range_normalizer.sv -----
// Top level of the image range normalizer: front end, job queue, back end.
// Depends on irn_pkg, irn_front, irn_fifo and irn_back.
//
// Usage: a frame is streamed twice on the slave channel. tdata carries the
// signed Q16.16 sample; tuser carries cmd (bit 0: 0 scan, 1 map),
// sample_is_nan (bit 1) and frame_first (bit 2). Scan transactions update
// the frame minimum and maximum and give no output; frame_first restarts
// both at zero. Map transactions each give one RGB pixel on the master
// channel (tdata: red 7:0, green 15:8, blue 23:16) under map_mode, which
// must be written through cfg_we / cfg_wdata only while the block is idle;
// the user is bound to this, as the block itself does not enforce it.
// Scans are taken whenever the queue has room. A map pixel that needs
// division (modes 0 and 1) runs through the bit-serial divider (one
// saturation check, then one quotient bit per cycle), and the back end
// takes no new job until it is done. Other pixels skip the divider.
// A two-entry queue separates the front end from the back end, so input is
// taken while the divider works or the receiver stalls; s_tready falls only
// when the queue is full. A stalled output holds its data. Reset clears the
// extremes, the mode, the queue and the output valid.
`default_nettype none
module image_range_normalizer import irn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample
  input  wire logic [2:0]  s_tuser,   // cmd, sample_is_nan, frame_first
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // red, green, blue
);

  job_t wr_data;
  job_t rd_data;
  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_not_empty;

  // Every transaction waits for queue room, which keeps scans and maps in
  // order with respect to the extremes they see.
  assign s_tready = !q_full;

  irn_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .take          (s_tvalid && s_tready),
    .cmd           (s_tuser[0]),
    .sample        (s_tdata),
    .sample_is_nan (s_tuser[1]),
    .frame_first   (s_tuser[2]),
    .q_wr          (q_wr),
    .q_data        (wr_data)
  );

  irn_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wr_data   (wr_data),
    .full      (q_full),
    .rd        (q_rd),
    .not_empty (q_not_empty),
    .rd_data   (rd_data)
  );

  irn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (rd_data),
    .q_rd        (q_rd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
`default_nettype wire

// ----- bench/image_range_normalizer_checker.sv -----
// Checker for the image range normalizer: watches both stream channels and
// the mode register port, predicts every pixel and compares it field by field.
// Depends on irn_pkg for the mode and command codes.
module image_range_normalizer_checker import irn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending_pixels,
  output int          pixels_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  pixel_t      expected_pixels[$];
  logic signed [63:0] low_mark, high_mark;
  logic [1:0]  mode;

  function automatic logic [7:0] clamp_quot(logic signed [63:0] num,
                                            logic signed [63:0] den);
    logic signed [63:0] q;
    if (num < 0 || den <= 0) return 8'd0;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Works out the pixel of one map transaction from the current extremes.
  function automatic pixel_t map_pixel(logic signed [63:0] s, logic nan);
    logic signed [63:0] span, e;
    logic [7:0] g;
    span = high_mark - low_mark;
    if (nan) return '{8'd0, 8'd0, 8'd255};
    case (mode)
      MODE_CENTER:  g = (span == 0) ? 8'd127 : clamp_quot(127*span + 127*s, span);
      MODE_STRETCH: g = (span == 0) ? 8'd0 : clamp_quot(255*(s - low_mark), span);
      MODE_OFFSET: begin
        e = s - low_mark;
        if (e < 0) return '{8'd0, 8'd0, 8'd255};
        if (e > 64'sd255 * 65536) return '{8'd255, 8'd255, 8'd255};
        g = e[23:16];
      end
      default: begin
        if (s < 0) g = 8'd0;
        else if (s > 64'sd255 * 65536) g = 8'd255;
        else g = 8'((s + 32768) / 65536);
      end
    endcase
    return '{g, g, g};
  endfunction

  always @(posedge clk) begin
    logic signed [63:0] s;
    pixel_t want, got;
    if (rst) begin
      low_mark  <= 0;
      high_mark <= 0;
      mode      <= MODE_CENTER;
      expected_pixels.delete();
      fail_count = 0;
      pixels_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red != want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green != want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            fail_count++;
          end
          if (got.blue != want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        s = $signed(s_tdata);
        if (s_tuser[0] == CMD_MAP) begin
          expected_pixels.push_back(map_pixel(s, s_tuser[1]));
        end else begin
          // A frame's first scan restarts both extremes at zero first.
          logic signed [63:0] lo, hi;
          lo = s_tuser[2] ? 64'sd0 : low_mark;
          hi = s_tuser[2] ? 64'sd0 : high_mark;
          if (!s_tuser[1]) begin
            if (s > hi) hi = s;
            if (s < lo) lo = s;
          end
          low_mark  <= lo;
          high_mark <= hi;
        end
      end
      if (cfg_we) mode <= cfg_wdata;
    end
    pending_pixels = expected_pixels.size();
  end
endmodule

// ----- bench/image_range_normalizer_tb.sv -----
// Testbench top for the image range normalizer: drives scan and map
// transactions and the mode register, and gives the verdict.
// Depends on irn_pkg, the block and image_range_normalizer_checker.
module image_range_normalizer_tb import irn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // sample
  logic [2:0]  s_tuser = '0;   // cmd, sample_is_nan, frame_first
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red, green, blue
  int          fail_count, pending_pixels, pixels_seen;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          stall_enable = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  image_range_normalizer uut (
    .clk, .rst, .cfg_we, .cfg_wdata, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  image_range_normalizer_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_wdata, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending_pixels, .pixels_seen
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls at random; a stall pattern is held for a run of cycles.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (!stall_enable) m_tready <= 1'b1;
      else begin
        hold = gap_length();
        if (hold > 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[image_range_normalizer] ERROR");
      $finish;
    end
  end

  // Sends one transaction, with an optional gap in front of it.
  task automatic send(logic cmd, logic [31:0] sample, logic nan, logic first);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= {first, nan, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Lets the block drain fully, then writes the mode register.
  task automatic write_mode(logic [1:0] m);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Samples mostly within a few hundred units, sometimes over the full range.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 600 * 65536)) - 300 * 65536);
      2:       return 32'($urandom_range(0, 300 * 65536));
      3:       return {{8{1'b0}}, 8'($urandom_range(0, 255)), 16'h8000};
      default: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
    endcase
  endfunction

  // One frame: a scan pass and then a map pass over the same samples,
  // with some stray noise transactions mixed in.
  task automatic run_frame(int len);
    logic [31:0] samples[$];
    logic        nans[$];
    for (int i = 0; i < len; i++) begin
      samples.push_back(rand_sample());
      nans.push_back($urandom_range(0, 19) == 0);
    end
    for (int i = 0; i < len; i++)
      send(CMD_SCAN, samples[i], nans[i], i == 0 || $urandom_range(0, 60) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(CMD_MAP, rand_sample(), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
      else
        send(CMD_MAP, samples[i], nans[i], 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [1:0] mode_order[4];
    mode_order = '{MODE_ROUND, MODE_CENTER, MODE_OFFSET, MODE_STRETCH};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero span right after reset, then extremes, NaN and rounding
    // edges under every mode.
    foreach (mode_order[k]) begin
      write_mode(mode_order[k]);
      send(CMD_SCAN, 32'h0, 1'b0, 1'b1);
      send(CMD_MAP, 32'h0001_0000, 1'b0, 1'b0);
      send(CMD_SCAN, 32'h8000_0000, 1'b0, 1'b0);
      send(CMD_SCAN, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send(CMD_SCAN, 32'h1234_5678, 1'b1, 1'b0);
      send(CMD_MAP, 32'h8000_0000, 1'b0, 1'b0);
      send(CMD_MAP, 32'h7FFF_FFFF, 1'b0, 1'b1);
      send(CMD_MAP, 32'h0000_8000, 1'b0, 1'b0);
      send(CMD_MAP, 32'h00FF_0000, 1'b0, 1'b0);
      send(CMD_MAP, 32'h00FF_0001, 1'b0, 1'b0);
      send(CMD_MAP, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send(CMD_SCAN, 32'h0000_0000, 1'b0, 1'b1);
      send(CMD_SCAN, 32'hFFFF_0000, 1'b0, 1'b0);
      send(CMD_MAP, 32'hFFFF_8000, 1'b0, 1'b0);
    end

    // Random frames, with a randomly chosen mode written at each drain point.
    while (items_sent < 1800) begin
      write_mode(2'($urandom_range(0, 3)));
      stall_enable = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 4)) run_frame($urandom_range(2, 30));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d transactions over all four modes; checked %0d pixels.",
             items_sent, pixels_seen);
    if (fail_count == 0 && pending_pixels == 0)
      $display("[image_range_normalizer] OK");
    else
      $display("[image_range_normalizer] ERROR");
    $finish;
  end
endmodule
